// ===== hdl/md5_message_digest_macros.svh =====
// ----------------------------------------------------------------------------
// md5 assertion macros
// shared concurrent assertion forms for the md5 digest block
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH

// implication checked on every clock edge outside reset
`define MD5_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5 package
// shared types, constants and round tables of the md5 digest block
// ----------------------------------------------------------------------------
package md5_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word_a;
      logic [31:0] digest_word_b;
      logic [31:0] digest_word_c;
      logic [31:0] digest_word_d;
   } rsp_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS = 6'd56;

   // byte source selects for the buffer write
   localparam logic [1:0] WSEL_DATA = 2'd0;
   localparam logic [1:0] WSEL_PAD  = 2'd1;
   localparam logic [1:0] WSEL_ZERO = 2'd2;
   localparam logic [1:0] WSEL_LEN  = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic       buf_we;
      logic [5:0] buf_addr;
      logic [1:0] buf_wsel;
      logic       count_inc;
      logic       len_latch;
      logic       round_start;
      logic       round_step;
      logic       chain_update;
      logic       chain_init;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [5:0] fill_pos;
      logic       round_last;
   } sts_type;

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] round_shift(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // message word index used by a round
   function automatic logic [3:0] round_word(input logic [5:0] r);
      logic [3:0] g;
      logic [7:0] m;
      case (r[5:4])
         2'd0: m = {2'b0, r};
         2'd1: m = 8'({2'b0, r} * 8'd5 + 8'd1);
         2'd2: m = 8'({2'b0, r} * 8'd3 + 8'd5);
         default: m = 8'({2'b0, r} * 8'd7);
      endcase
      g = m[3:0];
      return g;
   endfunction

endpackage

// ===== hdl/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5 controller
// sequences byte intake, padding, length append, rounds and digest output
// ----------------------------------------------------------------------------
`include "md5_message_digest_macros.svh"

module md5_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  md5_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output md5_pkg::cmd_type   cmd,
   input  md5_pkg::sts_type   sts
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_PAD   = 3'd2;
   localparam logic [2:0] ST_ZERO  = 3'd3;
   localparam logic [2:0] ST_LEN   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [5:0] ptr_ff, ptr_in;
   // closing flags: finishing message, and whether the length block is still due
   logic       closing_ff, closing_in;
   logic       final_ff, final_in;
   // remembers that the pad byte of this message is already in a buffer
   logic       padded_ff, padded_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      closing_in = closing_ff;
      final_in   = final_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.has_byte) begin
                  cmd.buf_we    = 1'b1;
                  cmd.buf_addr  = sts.fill_pos;
                  cmd.buf_wsel  = md5_pkg::WSEL_DATA;
                  cmd.count_inc = 1'b1;
               end
               closing_in = req_data.last;
               final_in   = 1'b0;
               if (req_data.has_byte && sts.fill_pos == 6'd63) begin
                  cmd.round_start = 1'b1;
                  state_in = ST_ROUND;
               end else if (req_data.last) begin
                  // pad position is the fill after this byte
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.buf_we    = 1'b1;
            cmd.buf_addr  = sts.fill_pos;
            cmd.buf_wsel  = md5_pkg::WSEL_PAD;
            cmd.len_latch = 1'b1;
            ptr_in = 6'(sts.fill_pos + 6'd1);
            if (sts.fill_pos == 6'd63) begin
               if (sts.fill_pos >= md5_pkg::LEN_POS) begin
                  cmd.round_start = 1'b1;
                  state_in = ST_ROUND;
               end
            end else if (sts.fill_pos == 6'd55) begin
               // pad lands just before the length field
               ptr_in   = md5_pkg::LEN_POS;
               state_in = ST_LEN;
            end else begin
               state_in = ST_ZERO;
            end
            final_in = (sts.fill_pos < md5_pkg::LEN_POS);
         end
         ST_ZERO: begin
            // zero up to byte 55, or to 63 when the length goes in the next block
            cmd.buf_we   = 1'b1;
            cmd.buf_addr = ptr_ff;
            cmd.buf_wsel = md5_pkg::WSEL_ZERO;
            ptr_in = 6'(ptr_ff + 6'd1);
            if (final_ff && ptr_ff == 6'd55) begin
               ptr_in   = md5_pkg::LEN_POS;
               state_in = ST_LEN;
            end else if (!final_ff && ptr_ff == 6'd63) begin
               cmd.round_start = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_LEN: begin
            cmd.buf_we   = 1'b1;
            cmd.buf_addr = ptr_ff;
            cmd.buf_wsel = md5_pkg::WSEL_LEN;
            ptr_in = 6'(ptr_ff + 6'd1);
            if (ptr_ff == 6'd63) begin
               cmd.round_start = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            if (sts.round_last) begin
               cmd.chain_update = 1'b1;
               if (!closing_ff) begin
                  state_in = ST_IDLE;
               end else if (final_ff) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            // pad already written goes to a fresh zero block, else pad now
            if (!padded_ff) begin
               state_in = ST_PAD;
            end else begin
               ptr_in   = 6'd0;
               final_in = 1'b1;
               state_in = ST_ZERO;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               cmd.chain_init = 1'b1;
               closing_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // pad tracking for the current message
   always_comb begin
      padded_in = padded_ff;
      if (state_ff == ST_IDLE) begin
         padded_in = 1'b0;
      end
      if (state_ff == ST_PAD) begin
         padded_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ptr_ff     <= '0;
         closing_ff <= 1'b0;
         final_ff   <= 1'b0;
         padded_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ptr_ff     <= ptr_in;
         closing_ff <= closing_in;
         final_ff   <= final_in;
         padded_ff  <= padded_in;
      end
   end

   `MD5_ASSERT_IMP(a_out_closing, state_ff == ST_OUT, closing_ff && final_ff,
      "digest shown outside a closing message")
   `MD5_ASSERT_IMP(a_ready_no_round, req_ready, !cmd.round_step,
      "rounds run while accepting bytes")
   `MD5_ASSERT_NEXT(a_start_round, cmd.round_start, state_ff == ST_ROUND,
      "round start without entering round state")

endmodule

// ===== hdl/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// md5 datapath
// block buffer, bit count, chaining words and one-round-per-cycle unit
// ----------------------------------------------------------------------------
`include "md5_message_digest_macros.svh"

module md5_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         data_byte,
   input  md5_pkg::cmd_type   cmd,
   output md5_pkg::sts_type   sts,
   output md5_pkg::rsp_type   rsp_data
);

   logic [31:0] buf_ff [16];
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff;
   logic [31:0] ch_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [5:0]  rnd_ff;
   logic [7:0]  wbyte;
   logic [31:0] word, f, t, rot;
   logic [3:0]  g;
   logic [4:0]  s;

   assign sts.fill_pos   = bits_ff[8:3];
   assign sts.round_last = (rnd_ff == 6'd63);
   assign rsp_data = '{ch_ff[0], ch_ff[1], ch_ff[2], ch_ff[3]};

   // byte written to the buffer
   always_comb begin
      case (cmd.buf_wsel)
         md5_pkg::WSEL_DATA: wbyte = data_byte;
         md5_pkg::WSEL_PAD:  wbyte = md5_pkg::PAD_BYTE;
         md5_pkg::WSEL_ZERO: wbyte = 8'h00;
         default:            wbyte = len_ff[{cmd.buf_addr[2:0], 3'b000} +: 8];
      endcase
   end

   // buffer as 16 little-endian words, one byte lane written per cycle
   always_ff @(posedge clock) begin
      if (cmd.buf_we) begin
         buf_ff[cmd.buf_addr[5:2]][{cmd.buf_addr[1:0], 3'b000} +: 8] <= wbyte;
      end
   end

   // round function
   always_comb begin
      g    = md5_pkg::round_word(rnd_ff);
      s    = md5_pkg::round_shift(rnd_ff);
      word = buf_ff[g];
      case (rnd_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      t   = a_ff + f + word + md5_pkg::round_k(rnd_ff);
      rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
   end

   // bit count
   always_comb begin
      bits_in = bits_ff;
      if (cmd.count_inc) begin
         bits_in = bits_ff + 64'd8;
      end
      if (cmd.chain_init) begin
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         rnd_ff  <= '0;
         ch_ff   <= '{md5_pkg::INIT_A, md5_pkg::INIT_B, md5_pkg::INIT_C, md5_pkg::INIT_D};
      end else begin
         bits_ff <= bits_in;
         if (cmd.len_latch && !cmd.round_step) begin
            len_ff <= bits_ff;
         end
         if (cmd.round_start) begin
            rnd_ff <= '0;
            a_ff <= ch_ff[0];
            b_ff <= ch_ff[1];
            c_ff <= ch_ff[2];
            d_ff <= ch_ff[3];
         end else if (cmd.round_step) begin
            rnd_ff <= 6'(rnd_ff + 6'd1);
            a_ff <= d_ff;
            b_ff <= b_ff + rot;
            c_ff <= b_ff;
            d_ff <= c_ff;
         end
         if (cmd.chain_update) begin
            ch_ff[0] <= ch_ff[0] + d_ff;
            ch_ff[1] <= ch_ff[1] + b_ff + rot;
            ch_ff[2] <= ch_ff[2] + b_ff;
            ch_ff[3] <= ch_ff[3] + c_ff;
         end
         if (cmd.chain_init) begin
            ch_ff <= '{md5_pkg::INIT_A, md5_pkg::INIT_B, md5_pkg::INIT_C, md5_pkg::INIT_D};
         end
      end
   end

   `MD5_ASSERT_NEXT(a_round_adv, cmd.round_step && !sts.round_last,
      rnd_ff == 6'($past(rnd_ff) + 6'd1), "round counter did not advance")
   `MD5_ASSERT_IMP(a_no_write_in_round, cmd.round_step, !cmd.buf_we,
      "buffer written during rounds")
   `MD5_ASSERT_NEXT(a_init_clears, cmd.chain_init, bits_ff == 64'd0,
      "bit count not cleared after digest")

endmodule

// ===== hdl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5 message digest
// byte-serial md5 hash with controller and round datapath
// ----------------------------------------------------------------------------
// usage: the req channel carries one word per item: a byte with has_byte,
// and last to close the message. an item with has_byte low and last low does
// nothing. the rsp channel returns one word, the four digest words, per
// message, after the item with last set.
// throughput: bytes are taken one per cycle while req_ready is high; the byte
// that fills a block holds req_ready low while the round unit runs its 64
// rounds, one md5 round per cycle.
// after the word with last: a pad byte, zero fill up to byte 55, eight length
// bytes and 64 rounds; when the length does not fit, zero fill to the block
// end, 64 rounds, a block of zeros and the length, and 64 more rounds.
// while the digest waits on rsp_ready the block holds it and takes no item.
// reset returns the chaining words to the initial vector and clears the
// bit count and control state; the block buffer is not cleared.
// ----------------------------------------------------------------------------
`include "md5_message_digest_macros.svh"

module md5_message_digest (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  md5_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output md5_pkg::rsp_type   rsp_data
);

   md5_pkg::cmd_type cmd;
   md5_pkg::sts_type sts;

   md5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   md5_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .data_byte (req_data.data_byte),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

   `MD5_ASSERT_IMP(a_excl, rsp_valid, !req_ready, "input taken while digest pending")
   `MD5_ASSERT_NEXT(a_rsp_done, rsp_valid && rsp_ready, !rsp_valid,
      "digest repeated")

endmodule

// ===== test/md5_message_digest_checker.sv =====
// ----------------------------------------------------------------------------
// md5 digest checker
// watches the req and rsp channels, runs its own byte-serial md5 on every
// accepted word and compares each returned digest with the oldest prediction
// ----------------------------------------------------------------------------
module md5_message_digest_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  md5_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  md5_pkg::rsp_type rsp_data,
   output int               failures,
   output int               digests_pending
);

   localparam logic [31:0] SINE_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
   localparam int ROT_AMOUNT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

   logic [31:0]      hash_state [4];
   logic [7:0]       msg_block [64];
   logic [63:0]      bit_count;
   md5_pkg::rsp_type digest_queue [$];

   // one 64-round compression of msg_block into hash_state
   function automatic void md5_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int g;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            f = (b & c) | (~b & d); g = r;
         end else if (r < 32) begin
            f = (b & d) | (c & ~d); g = (5*r + 1) % 16;
         end else if (r < 48) begin
            f = b ^ c ^ d; g = (3*r + 5) % 16;
         end else begin
            f = c ^ (b | ~d); g = (7*r) % 16;
         end
         t = a + f + w[g] + SINE_TABLE[r];
         a = d; d = c; c = b;
         b = b + ((t << ROT_AMOUNT[(r/16)*4 + r%4]) | (t >> (32 - ROT_AMOUNT[(r/16)*4 + r%4])));
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
   endfunction

   function automatic void restart_hash();
      hash_state[0] = md5_pkg::INIT_A; hash_state[1] = md5_pkg::INIT_B;
      hash_state[2] = md5_pkg::INIT_C; hash_state[3] = md5_pkg::INIT_D;
      bit_count = '0;
   endfunction

   // absorb one accepted word; pad and queue the digest on last
   function automatic void absorb_word(md5_pkg::req_type w);
      int pos;
      logic [63:0] total;
      if (w.has_byte) begin
         pos = int'(bit_count[8:3]);
         msg_block[pos] = w.data_byte;
         bit_count += 64'd8;
         if (pos == 63) md5_compress();
      end
      if (!w.last) return;
      total = bit_count;
      pos = int'(bit_count[8:3]);
      msg_block[pos] = md5_pkg::PAD_BYTE;
      for (int k = pos + 1; k < 64; k++) msg_block[k] = 8'h00;
      if (pos >= 56) begin
         md5_compress();
         for (int k = 0; k < 64; k++) msg_block[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) msg_block[56+k] = total[8*k +: 8];
      md5_compress();
      digest_queue.push_back('{hash_state[0], hash_state[1], hash_state[2], hash_state[3]});
      restart_hash();
   endfunction

   initial begin
      failures = 0;
      digests_pending = 0;
      restart_hash();
      for (int k = 0; k < 64; k++) msg_block[k] = 8'h00;
   end

   // sample both channels at the edge
   always @(posedge clock) begin
      md5_pkg::rsp_type exp_digest;
      if (reset) begin
         restart_hash();
      end else begin
         if (req_valid && req_ready) absorb_word(req_data);
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected digest word %h", $time, rsp_data);
               failures++;
            end else begin
               exp_digest = digest_queue.pop_front();
               if (rsp_data.digest_word_a !== exp_digest.digest_word_a ||
                   rsp_data.digest_word_b !== exp_digest.digest_word_b ||
                   rsp_data.digest_word_c !== exp_digest.digest_word_c ||
                   rsp_data.digest_word_d !== exp_digest.digest_word_d) begin
                  $display("%0t: digest mismatch expected %h actual %h",
                           $time, exp_digest, rsp_data);
                  failures++;
               end
            end
         end
      end
      digests_pending = int'(digest_queue.size());
   end
endmodule

// ===== test/md5_message_digest_test.sv =====
// ----------------------------------------------------------------------------
// md5 digest test
// drives directed and random messages of byte words with random gaps and
// digest back-pressure; the checker predicts and compares every digest
// ----------------------------------------------------------------------------
module md5_message_digest_test;

   localparam int STALL_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   md5_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   md5_pkg::rsp_type rsp_data;
   int               failures;
   int               digests_pending;
   int               idle_cycles = 0;
   bit               bursty = 1'b0;

   always #1 clock = ~clock;

   md5_message_digest dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));

   md5_message_digest_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .failures(failures), .digests_pending(digests_pending));

   // send one word, with a random gap first unless in a burst stretch
   task automatic send_word(logic [7:0] b, logic has, logic fin);
      int gap;
      gap = bursty ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, has_byte: has, last: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // message of n random bytes, closed by last on the final byte or an empty word
   task automatic send_message(int n, bit noise);
      bit empty_close;
      empty_close = (n == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
         if (noise && $urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(8'($urandom), 1'b1, !empty_close && i == n - 1);
      end
      if (empty_close) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   // digest side: random stall per word, with stall-free stretches
   initial begin
      int wait_n;
      @(negedge reset);
      forever begin
         wait_n = bursty ? 0 : $urandom_range(0, 12);
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int sent;
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: empty message, a lone no-op word, byte extremes, pad boundaries
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'hff, 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'haa, 1'b1, 1'b0);
      send_word(8'h55, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      send_message(55, 1'b0);
      send_message(56, 1'b0);
      send_message(63, 1'b0);
      send_message(64, 1'b0);
      send_message(65, 1'b0);
      // random messages, mostly short, a few spanning several blocks
      sent = 0;
      while (sent < 300) begin
         bursty = ($urandom_range(0, 5) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 20);
         send_message(len, 1'b1);
         sent += len + 1;
      end
      req_valid <= 1'b0;
      bursty = 1'b0;
      while (digests_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/md5_pkg.sv
hdl/md5_ctrl.sv
hdl/md5_datapath.sv
hdl/md5_message_digest.sv
test/md5_message_digest_checker.sv
test/md5_message_digest_test.sv
